>>> rtl/aiu_pkg.sv
// shared types, operation codes and flag positions of the integer arithmetic unit
`timescale 1ns / 1ps
`default_nettype none
package aiu_pkg;

   localparam int unsigned DivSteps = 32;

   localparam logic [3:0] MODE_DIVS = 4'd0;
   localparam logic [3:0] MODE_DIVU = 4'd1;
   localparam logic [3:0] MODE_MULS = 4'd2;
   localparam logic [3:0] MODE_MULU = 4'd3;
   localparam logic [3:0] MODE_NEG  = 4'd4;
   localparam logic [3:0] MODE_NEGX = 4'd5;
   localparam logic [3:0] MODE_CMP  = 4'd6;
   localparam logic [3:0] MODE_TST  = 4'd7;
   localparam logic [3:0] MODE_CLR  = 4'd8;
   localparam logic [3:0] MODE_EXT  = 4'd9;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_WORD = 2'd1;

   localparam int unsigned FLAG_X = 4;
   localparam int unsigned FLAG_N = 3;
   localparam int unsigned FLAG_Z = 2;
   localparam int unsigned FLAG_V = 1;
   localparam int unsigned FLAG_C = 0;

   typedef struct packed {
      logic        is_div;
      logic        signed_div;
      logic        quo_neg;
      logic        rem_neg;
      logic [31:0] dst;
      logic [4:0]  flags;
      logic [31:0] res;
      logic        wr;
      logic [4:0]  fout;
      logic        dz;
   } aiu_word_type;

   typedef struct packed {
      logic [15:0] rem;
      logic [31:0] quo;
      logic [15:0] dvs;
   } aiu_div_type;

   function automatic logic [31:0] size_mask(input logic [1:0] size);
      logic [31:0] m;
      case (size)
         SIZE_BYTE: m = 32'h0000_00ff;
         SIZE_WORD: m = 32'h0000_ffff;
         default:   m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

   function automatic logic [31:0] size_msb(input logic [1:0] size);
      logic [31:0] m;
      case (size)
         SIZE_BYTE: m = 32'h0000_0080;
         SIZE_WORD: m = 32'h0000_8000;
         default:   m = 32'h8000_0000;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

>>> rtl/m68k_integer_arith_unit.sv
// top level of the pipelined 68000 integer arithmetic unit
`timescale 1ns / 1ps
`default_nettype none
// usage:
//   a word is taken on req_* at a rising edge with start high; busy is
//   always low, so one word can be given every cycle
//   each word gives exactly one result on rsp_*, marked by rsp_valid for
//   one cycle; results leave in the order the words came in
//   every operation passes through one input register, a chain of 32
//   division cells (one quotient bit per cell) and one output register;
//   throughput is one word per cycle
//   divs and divu run on magnitudes through the cells and get their signs,
//   overflow check and flags at the end; other operations are done at entry
//   and ride along the chain
//   reset clears the valid bits of every stage; words in flight are dropped
//   the receiver cannot stall, so nothing is held back
module m68k_integer_arith_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [3:0]  req_mode,
   input  wire logic [1:0]  req_size,
   input  wire logic [31:0] req_operand_src,
   input  wire logic [31:0] req_operand_dst,
   input  wire logic [4:0]  req_flags_in,
   output logic             rsp_valid,
   output logic [31:0]      rsp_result_value,
   output logic             rsp_write_result,
   output logic [4:0]       rsp_flags_out,
   output logic             rsp_divide_by_zero
);
   import aiu_pkg::*;

   aiu_word_type prep_word, in_word_ff;
   aiu_div_type  prep_div, in_div_ff;
   logic         in_valid_ff;

   logic         chain_valid [0:DivSteps];
   aiu_word_type chain_word  [0:DivSteps];
   aiu_div_type  chain_div   [0:DivSteps];

   logic [31:0]  post_result;
   logic         post_wr, post_dz;
   logic [4:0]   post_flags;

   logic         out_valid_ff;
   logic [31:0]  out_result_ff;
   logic         out_wr_ff, out_dz_ff;
   logic [4:0]   out_flags_ff;

   aiu_prep u_prep (
      .mode  (req_mode),
      .size  (req_size),
      .src   (req_operand_src),
      .dst   (req_operand_dst),
      .flags (req_flags_in),
      .word  (prep_word),
      .div   (prep_div)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start;
      end
      in_word_ff <= prep_word;
      in_div_ff  <= prep_div;
   end

   assign chain_valid[0] = in_valid_ff;
   assign chain_word[0]  = in_word_ff;
   assign chain_div[0]   = in_div_ff;

   for (genvar i = 0; i < DivSteps; i++) begin : g_cell
      aiu_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (chain_valid[i]),
         .word_in   (chain_word[i]),
         .div_in    (chain_div[i]),
         .valid_out (chain_valid[i+1]),
         .word_out  (chain_word[i+1]),
         .div_out   (chain_div[i+1])
      );
   end

   aiu_post u_post (
      .word           (chain_word[DivSteps]),
      .div            (chain_div[DivSteps]),
      .result_value   (post_result),
      .write_result   (post_wr),
      .flags_out      (post_flags),
      .divide_by_zero (post_dz)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= chain_valid[DivSteps];
      end
      out_result_ff <= post_result;
      out_wr_ff     <= post_wr;
      out_flags_ff  <= post_flags;
      out_dz_ff     <= post_dz;
   end

   assign busy               = 1'b0;
   assign rsp_valid          = out_valid_ff;
   assign rsp_result_value   = out_result_ff;
   assign rsp_write_result   = out_wr_ff;
   assign rsp_flags_out      = out_flags_ff;
   assign rsp_divide_by_zero = out_dz_ff;

endmodule
`default_nettype wire

>>> rtl/aiu_prep.sv
// operand preparation: the non-divide operations and divider setup
`timescale 1ns / 1ps
`default_nettype none
module aiu_prep (
   input  wire logic [3:0]          mode,
   input  wire logic [1:0]          size,
   input  wire logic [31:0]         src,
   input  wire logic [31:0]         dst,
   input  wire logic [4:0]          flags,
   output aiu_pkg::aiu_word_type    word,
   output aiu_pkg::aiu_div_type     div
);
   import aiu_pkg::*;

   logic [31:0]        m, msb, r, x;
   logic               sm, dm, rm, sg;
   logic signed [33:0] prod;

   always_comb begin
      m    = size_mask(size);
      msb  = size_msb(size);
      sg   = (mode == MODE_MULS);
      prod = $signed({{2{src[15] & sg}}, src[15:0]}) * $signed({{2{dst[15] & sg}}, dst[15:0]});
      x    = {31'd0, (mode == MODE_NEGX) & flags[FLAG_X]};
      r    = 32'd0;
      sm   = 1'b0;
      dm   = 1'b0;
      rm   = 1'b0;

      word.is_div     = 1'b0;
      word.signed_div = 1'b0;
      word.quo_neg    = 1'b0;
      word.rem_neg    = 1'b0;
      word.dst        = dst;
      word.flags      = flags;
      word.res        = dst;
      word.wr         = 1'b0;
      word.fout       = flags;
      word.dz         = 1'b0;
      div.rem         = 16'd0;
      div.quo         = dst;
      div.dvs         = src[15:0];

      unique case (mode)
         MODE_DIVS: begin
            word.is_div     = 1'b1;
            word.signed_div = 1'b1;
            word.dz         = (src[15:0] == 16'd0);
            word.quo_neg    = dst[31] ^ src[15];
            word.rem_neg    = dst[31];
            div.quo         = dst[31] ? (32'd0 - dst) : dst;
            div.dvs         = src[15] ? (16'd0 - src[15:0]) : src[15:0];
         end
         MODE_DIVU: begin
            word.is_div = 1'b1;
            word.dz     = (src[15:0] == 16'd0);
         end
         MODE_MULS, MODE_MULU: begin
            word.res  = prod[31:0];
            word.wr   = 1'b1;
            word.fout = {flags[FLAG_X], prod[31], prod[31:0] == 32'd0, 2'b00};
         end
         MODE_NEG, MODE_NEGX: begin
            r  = (32'd0 - (dst & m) - x) & m;
            dm = (dst & msb) != 32'd0;
            rm = (r & msb) != 32'd0;
            word.res  = (dst & ~m) | r;
            word.wr   = 1'b1;
            word.fout = 5'd0;
            word.fout[FLAG_N] = rm;
            word.fout[FLAG_V] = dm & rm;
            word.fout[FLAG_C] = dm | rm;
            word.fout[FLAG_X] = dm | rm;
            if (mode == MODE_NEG) begin
               word.fout[FLAG_Z] = (r == 32'd0);
            end else begin
               word.fout[FLAG_Z] = (r == 32'd0) & flags[FLAG_Z];
            end
         end
         MODE_CMP: begin
            r  = ((dst & m) - (src & m)) & m;
            sm = (src & msb) != 32'd0;
            dm = (dst & msb) != 32'd0;
            rm = (r & msb) != 32'd0;
            word.res  = (dst & ~m) | r;
            word.fout = {flags[FLAG_X], rm, r == 32'd0,
                         (!sm && dm && !rm) || (sm && !dm && rm),
                         (sm && !dm) || (rm && !dm) || (sm && rm)};
         end
         MODE_TST: begin
            word.fout = {flags[FLAG_X], (dst & msb) != 32'd0, (dst & m) == 32'd0, 2'b00};
         end
         MODE_CLR: begin
            word.res  = dst & ~m;
            word.wr   = 1'b1;
            word.fout = {flags[FLAG_X], 1'b0, 1'b1, 2'b00};
         end
         MODE_EXT: begin
            word.wr = 1'b1;
            if (size == SIZE_BYTE || size == SIZE_WORD) begin
               r = {dst[31:16], {8{dst[7]}}, dst[7:0]};
               word.fout = {flags[FLAG_X], r[15], r[15:0] == 16'd0, 2'b00};
            end else begin
               r = {{16{dst[15]}}, dst[15:0]};
               word.fout = {flags[FLAG_X], r[31], r == 32'd0, 2'b00};
            end
            word.res = r;
         end
         default: begin
            word.fout = flags;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/aiu_div_cell.sv
// one restoring division step with its pipeline register
`timescale 1ns / 1ps
`default_nettype none
module aiu_div_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 valid_in,
   input  aiu_pkg::aiu_word_type     word_in,
   input  aiu_pkg::aiu_div_type      div_in,
   output logic                      valid_out,
   output aiu_pkg::aiu_word_type     word_out,
   output aiu_pkg::aiu_div_type      div_out
);
   import aiu_pkg::*;

   logic         valid_ff;
   aiu_word_type word_ff;
   aiu_div_type  div_ff, div_in_next;
   logic [16:0]  trial, diff;

   always_comb begin
      trial       = {div_in.rem, div_in.quo[31]};
      diff        = trial - {1'b0, div_in.dvs};
      div_in_next = div_in;
      if (trial >= {1'b0, div_in.dvs}) begin
         div_in_next.rem = diff[15:0];
         div_in_next.quo = {div_in.quo[30:0], 1'b1};
      end else begin
         div_in_next.rem = trial[15:0];
         div_in_next.quo = {div_in.quo[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
      div_ff  <= div_in_next;
   end

   assign valid_out = valid_ff;
   assign word_out  = word_ff;
   assign div_out   = div_ff;

endmodule
`default_nettype wire

>>> rtl/aiu_post.sv
// divide finish: sign fix-up, overflow check and flags; other words pass through unchanged
`timescale 1ns / 1ps
`default_nettype none
module aiu_post (
   input  aiu_pkg::aiu_word_type word,
   input  aiu_pkg::aiu_div_type  div,
   output logic [31:0]           result_value,
   output logic                  write_result,
   output logic [4:0]            flags_out,
   output logic                  divide_by_zero
);
   import aiu_pkg::*;

   logic        ovf;
   logic [15:0] qv, rv;

   always_comb begin
      if (word.signed_div) begin
         ovf = word.quo_neg ? (div.quo > 32'h0000_8000) : (div.quo > 32'h0000_7fff);
      end else begin
         ovf = div.quo[31:16] != 16'd0;
      end
      qv = word.quo_neg ? (16'd0 - div.quo[15:0]) : div.quo[15:0];
      rv = word.rem_neg ? (16'd0 - div.rem) : div.rem;

      result_value   = word.res;
      write_result   = word.wr;
      flags_out      = word.fout;
      divide_by_zero = word.dz;
      if (word.is_div && !word.dz) begin
         if (ovf) begin
            flags_out = {word.flags[4:2], 1'b1, 1'b0};
         end else begin
            result_value = {rv, qv};
            write_result = 1'b1;
            flags_out    = {word.flags[FLAG_X], qv[15], qv == 16'd0, 2'b00};
         end
      end
   end

endmodule
`default_nettype wire

>>> tb/sv/tb_m68k_integer_arith_unit.sv
// self-checking testbench of the 68000 integer arithmetic unit against a built-in predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_m68k_integer_arith_unit;
   import aiu_pkg::*;

   localparam logic [1:0] SIZE_LONG_C = 2'd2;

   typedef struct {
      logic [3:0]  mode;
      logic [1:0]  size;
      logic [31:0] src;
      logic [31:0] dst;
      logic [4:0]  flags;
   } op_word_type;

   typedef struct {
      logic [31:0] value;
      logic        wr;
      logic [4:0]  flags;
      logic        dz;
   } op_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [3:0]  req_mode = '0;
   logic [1:0]  req_size = '0;
   logic [31:0] req_operand_src = '0;
   logic [31:0] req_operand_dst = '0;
   logic [4:0]  req_flags_in = '0;
   logic        rsp_valid;
   logic [31:0] rsp_result_value;
   logic        rsp_write_result;
   logic [4:0]  rsp_flags_out;
   logic        rsp_divide_by_zero;

   op_word_type   pending_words[$];
   op_result_type expected_results[$];
   int            error_count = 0;
   int            words_sent = 0;
   int            results_seen = 0;
   int            idle_left = 0;
   bit            allow_idle = 1'b1;
   bit            hold_sender = 1'b0;
   logic          took_ff = 1'b0;

   m68k_integer_arith_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_size(req_size),
      .req_operand_src(req_operand_src), .req_operand_dst(req_operand_dst),
      .req_flags_in(req_flags_in), .rsp_valid(rsp_valid),
      .rsp_result_value(rsp_result_value), .rsp_write_result(rsp_write_result),
      .rsp_flags_out(rsp_flags_out), .rsp_divide_by_zero(rsp_divide_by_zero)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [4:0] nz_of(logic [31:0] r, logic [31:0] m, logic [31:0] msb);
      logic [4:0] f;
      f = '0;
      f[FLAG_N] = (r & msb) != 0;
      f[FLAG_Z] = (r & m) == 0;
      return f;
   endfunction

   function automatic op_result_type predict_alu(op_word_type w);
      op_result_type o;
      logic [31:0] m, msb, r, q32, rm32;
      logic signed [63:0] a, b, q, rs, p;
      logic sm, dm, rmb, xin;
      m = (w.size == SIZE_BYTE) ? 32'hff : (w.size == SIZE_WORD) ? 32'hffff : 32'hffffffff;
      msb = (w.size == SIZE_BYTE) ? 32'h80 : (w.size == SIZE_WORD) ? 32'h8000 : 32'h80000000;
      o.value = w.dst;
      o.wr = 1'b0;
      o.flags = w.flags;
      o.dz = 1'b0;
      case (w.mode)
         MODE_DIVS: begin
            b = $signed(w.src[15:0]);
            if (b == 0) o.dz = 1'b1;
            else begin
               a = $signed(w.dst);
               q = a / b;
               rs = a % b;
               if (q < -32768 || q > 32767) begin
                  o.flags = (w.flags & 5'b11100) | 5'b00010;
               end else begin
                  o.value = {rs[15:0], q[15:0]};
                  o.wr = 1'b1;
                  o.flags = (w.flags & 5'b10000) | nz_of({16'b0, q[15:0]}, 32'hffff, 32'h8000);
               end
            end
         end
         MODE_DIVU: begin
            if (w.src[15:0] == 0) o.dz = 1'b1;
            else begin
               q32 = w.dst / {16'b0, w.src[15:0]};
               rm32 = w.dst % {16'b0, w.src[15:0]};
               if (q32 > 32'hffff) begin
                  o.flags = (w.flags & 5'b11100) | 5'b00010;
               end else begin
                  o.value = {rm32[15:0], q32[15:0]};
                  o.wr = 1'b1;
                  o.flags = (w.flags & 5'b10000) | nz_of(q32, 32'hffff, 32'h8000);
               end
            end
         end
         MODE_MULS, MODE_MULU: begin
            if (w.mode == MODE_MULS) begin
               p = $signed(w.src[15:0]) * $signed(w.dst[15:0]);
               o.value = p[31:0];
            end else begin
               o.value = {16'b0, w.src[15:0]} * {16'b0, w.dst[15:0]};
            end
            o.wr = 1'b1;
            o.flags = (w.flags & 5'b10000) | nz_of(o.value, 32'hffffffff, 32'h80000000);
         end
         MODE_NEG, MODE_NEGX: begin
            xin = (w.mode == MODE_NEGX) && w.flags[FLAG_X];
            r = (32'd0 - (w.dst & m) - {31'b0, xin}) & m;
            dm = (w.dst & msb) != 0;
            rmb = (r & msb) != 0;
            o.value = (w.dst & ~m) | r;
            o.wr = 1'b1;
            o.flags = '0;
            o.flags[FLAG_N] = rmb;
            o.flags[FLAG_V] = dm && rmb;
            o.flags[FLAG_C] = dm || rmb;
            o.flags[FLAG_X] = dm || rmb;
            if (r == 0) o.flags[FLAG_Z] = (w.mode == MODE_NEG) ? 1'b1 : w.flags[FLAG_Z];
         end
         MODE_CMP: begin
            r = ((w.dst & m) - (w.src & m)) & m;
            sm = (w.src & msb) != 0;
            dm = (w.dst & msb) != 0;
            rmb = (r & msb) != 0;
            o.value = (w.dst & ~m) | r;
            o.flags = (w.flags & 5'b10000) | nz_of(r, m, msb);
            o.flags[FLAG_V] = (!sm && dm && !rmb) || (sm && !dm && rmb);
            o.flags[FLAG_C] = (sm && !dm) || (rmb && !dm) || (sm && rmb);
         end
         MODE_TST: o.flags = (w.flags & 5'b10000) | nz_of(w.dst, m, msb);
         MODE_CLR: begin
            o.value = w.dst & ~m;
            o.wr = 1'b1;
            o.flags = (w.flags & 5'b10000) | 5'b00100;
         end
         MODE_EXT: begin
            if (w.size[1]) begin
               o.value = {{16{w.dst[15]}}, w.dst[15:0]};
               o.flags = (w.flags & 5'b10000) | nz_of(o.value, 32'hffffffff, 32'h80000000);
            end else begin
               o.value = {w.dst[31:16], {8{w.dst[7]}}, w.dst[7:0]};
               o.flags = (w.flags & 5'b10000) | nz_of(o.value, 32'hffff, 32'h8000);
            end
            o.wr = 1'b1;
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'hffffffff;
         2: return 32'h80000000;
         3: return 32'h7fffffff;
         4: return $urandom_range(0, 255);
         5: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic add_word(logic [3:0] md, logic [1:0] sz, logic [31:0] s, logic [31:0] d,
                           logic [4:0] f);
      op_word_type w;
      w.mode = md;
      w.size = sz;
      w.src = s;
      w.dst = d;
      w.flags = f;
      pending_words.push_back(w);
   endtask

   // predict each word at the edge that accepts it
   always @(posedge clock) begin
      op_word_type w;
      w.mode = req_mode;
      w.size = req_size;
      w.src = req_operand_src;
      w.dst = req_operand_dst;
      w.flags = req_flags_in;
      if (!reset && start && !busy) begin
         expected_results.push_back(predict_alu(w));
         words_sent++;
      end
      took_ff <= !reset && start && !busy;
   end

   always @(negedge clock) begin
      op_word_type cur_word;
      logic take_next;
      if (reset) begin
         start <= 1'b0;
      end else begin
         take_next = !start || took_ff;
         if (take_next) begin
            if (idle_left > 0) begin
               idle_left <= idle_left - 1;
               start <= 1'b0;
            end else if (allow_idle && $urandom_range(0, 9) == 0) begin
               idle_left <= $urandom_range(0, 2);
               start <= 1'b0;
            end else if (pending_words.size() > 0 && !hold_sender) begin
               cur_word = pending_words.pop_front();
               start <= 1'b1;
               req_mode <= cur_word.mode;
               req_size <= cur_word.size;
               req_operand_src <= cur_word.src;
               req_operand_dst <= cur_word.dst;
               req_flags_in <= cur_word.flags;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      op_result_type e;
      if (!reset && rsp_valid) begin
         results_seen <= results_seen + 1;
         if (expected_results.size() == 0) begin
            $error("result with no word outstanding: value %h", rsp_result_value);
            error_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_result_value !== e.value) begin
               $error("result_value expected %h actual %h", e.value, rsp_result_value);
               error_count++;
            end
            if (rsp_write_result !== e.wr) begin
               $error("write_result expected %b actual %b", e.wr, rsp_write_result);
               error_count++;
            end
            if (rsp_flags_out !== e.flags) begin
               $error("flags_out expected %b actual %b", e.flags, rsp_flags_out);
               error_count++;
            end
            if (rsp_divide_by_zero !== e.dz) begin
               $error("divide_by_zero expected %b actual %b", e.dz, rsp_divide_by_zero);
               error_count++;
            end
         end
      end
   end

   initial begin
      #100000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int k;
      logic [3:0] md;
      // directed words
      add_word(MODE_DIVS, SIZE_WORD, 32'h0, 32'h1234, 5'b11111);
      add_word(MODE_DIVU, SIZE_WORD, 32'hffff0000, 32'h1234, 5'b00000);
      add_word(MODE_DIVS, SIZE_WORD, 32'h1, 32'h00010000, 5'b11111);
      add_word(MODE_DIVU, SIZE_WORD, 32'h1, 32'h00010000, 5'b01101);
      add_word(MODE_DIVS, SIZE_WORD, 32'hffff, 32'h80000000, 5'b10000);
      add_word(MODE_DIVS, SIZE_WORD, 32'hfff9, 32'hffffffd5, 5'b00000);
      add_word(MODE_DIVU, SIZE_WORD, 32'hffff, 32'hfffeffff, 5'b10000);
      add_word(MODE_MULS, SIZE_LONG_C, 32'h8000, 32'h8000, 5'b11111);
      add_word(MODE_MULU, SIZE_WORD, 32'hffff, 32'hffff, 5'b00000);
      add_word(MODE_MULS, SIZE_WORD, 32'h0, 32'hffff, 5'b10000);
      add_word(MODE_NEG, SIZE_BYTE, 0, 32'h80, 5'b00000);
      add_word(MODE_NEG, SIZE_WORD, 0, 32'h0, 5'b11111);
      add_word(MODE_NEGX, SIZE_LONG_C, 0, 32'h0, 5'b10100);
      add_word(MODE_NEGX, SIZE_BYTE, 0, 32'hffffff00, 5'b00100);
      add_word(MODE_NEGX, SIZE_WORD, 0, 32'h1, 5'b10100);
      add_word(MODE_CMP, SIZE_BYTE, 32'h7f, 32'h80, 5'b10000);
      add_word(MODE_CMP, SIZE_WORD, 32'h8000, 32'h7fff, 5'b00000);
      add_word(MODE_CMP, 2'd3, 32'hffffffff, 32'h0, 5'b11111);
      add_word(MODE_TST, SIZE_BYTE, 0, 32'hffffff00, 5'b01111);
      add_word(MODE_TST, SIZE_LONG_C, 0, 32'h80000000, 5'b10000);
      add_word(MODE_CLR, SIZE_WORD, 0, 32'hffffffff, 5'b11011);
      add_word(MODE_EXT, SIZE_BYTE, 0, 32'h12345680, 5'b10000);
      add_word(MODE_EXT, SIZE_LONG_C, 0, 32'h00008000, 5'b00000);
      add_word(MODE_EXT, 2'd3, 0, 32'hffff0000, 5'b11111);
      add_word(4'd15, SIZE_WORD, 32'hffffffff, 32'hdeadbeef, 5'b10101);
      for (k = 0; k < 1600; k++) begin
         md = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
         add_word(md, 2'($urandom_range(0, 3)), rand_operand(), rand_operand(), 5'($urandom));
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (pending_words.size() < 800);
      hold_sender = 1'b1;
      wait (expected_results.size() == 0 && !start);
      hold_sender = 1'b0;
      wait (pending_words.size() < 200);
      allow_idle = 1'b0;
      wait (pending_words.size() == 0);
      @(posedge clock);
      wait (expected_results.size() == 0);
      repeat (40) @(posedge clock);
      $display("covered %0d words over all ten operations, all sizes, unknown modes,",
               words_sent);
      $display("zero divisors and division overflow; %0d results checked", results_seen);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
rtl/aiu_pkg.sv
rtl/aiu_prep.sv
rtl/aiu_div_cell.sv
rtl/aiu_post.sv
rtl/m68k_integer_arith_unit.sv
tb/sv/tb_m68k_integer_arith_unit.sv
